// ===== hdl/pwlt_pkg.sv =====
// Shared types, register indexes, phase codes and helpers for the pulse-width line transmitter.
package pwlt_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int TICK_W      = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_START_LOW   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_START_PULSE = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_START_GAP   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_LONG_HIGH   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SHORT_HIGH  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_BIT_PERIOD  = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_STOP_HIGH   = 3'd6;

  localparam logic [2:0] PH_IDLE        = 3'd0;
  localparam logic [2:0] PH_START_LOW   = 3'd1;
  localparam logic [2:0] PH_START_PULSE = 3'd2;
  localparam logic [2:0] PH_START_GAP   = 3'd3;
  localparam logic [2:0] PH_BIT_HIGH    = 3'd4;
  localparam logic [2:0] PH_BIT_LOW     = 3'd5;
  localparam logic [2:0] PH_STOP        = 3'd6;

  typedef struct packed {
    logic [TICK_W-1:0] start_low_ticks;
    logic [TICK_W-1:0] start_pulse_ticks;
    logic [TICK_W-1:0] start_gap_ticks;
    logic [TICK_W-1:0] long_high_ticks;
    logic [TICK_W-1:0] short_high_ticks;
    logic [TICK_W-1:0] bit_period_ticks;
    logic [TICK_W-1:0] stop_high_ticks;
  } cfg_t;

  typedef struct packed {
    logic line_level;
    logic drive_enable;
    logic in_progress;
    logic accepted;
    logic frame_done;
  } result_t;

  // A zero duration counts as one tick.
  function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] v);
    at_least_one = (v == '0) ? TICK_W'(1) : v;
  endfunction

  function automatic logic phase_level(input logic [2:0] ph);
    case (ph)
      PH_START_LOW, PH_START_GAP, PH_BIT_LOW: phase_level = 1'b0;
      default:                                phase_level = 1'b1;
    endcase
  endfunction

endpackage

// ===== hdl/pwlt_if.sv =====
// Channel interfaces: send/tick requests, line results and register writes.
interface pwlt_req_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] data_byte;
  logic       line_busy;
  modport source (output valid, action, data_byte, line_busy, input ready);
  modport sink   (input valid, action, data_byte, line_busy, output ready);
endinterface

interface pwlt_rsp_if;
  logic valid;
  logic ready;
  logic line_level;
  logic drive_enable;
  logic in_progress;
  logic accepted;
  logic frame_done;
  modport source (output valid, line_level, drive_enable, in_progress, accepted, frame_done,
                  input ready);
  modport sink   (input valid, line_level, drive_enable, in_progress, accepted, frame_done,
                  output ready);
endinterface

interface pwlt_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [7:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/pwlt_cfg_regs.sv =====
// Timing register file written through the configuration channel.
module pwlt_cfg_regs
  import pwlt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  pwlt_cfg_if.sink   cfg,
  output cfg_t       regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.start_low_ticks   <= 8'd10;
      regs.start_pulse_ticks <= 8'd1;
      regs.start_gap_ticks   <= 8'd9;
      regs.long_high_ticks   <= 8'd7;
      regs.short_high_ticks  <= 8'd3;
      regs.bit_period_ticks  <= 8'd10;
      regs.stop_high_ticks   <= 8'd20;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_START_LOW:   regs.start_low_ticks   <= cfg.data;
        REG_START_PULSE: regs.start_pulse_ticks <= cfg.data;
        REG_START_GAP:   regs.start_gap_ticks   <= cfg.data;
        REG_LONG_HIGH:   regs.long_high_ticks   <= cfg.data;
        REG_SHORT_HIGH:  regs.short_high_ticks  <= cfg.data;
        REG_BIT_PERIOD:  regs.bit_period_ticks  <= cfg.data;
        REG_STOP_HIGH:   regs.stop_high_ticks   <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/pwlt_frame_ctrl.sv =====
// Frame sequencer: phase, bit counter, tick counter, shift register and result register.
module pwlt_frame_ctrl
  import pwlt_pkg::*;
#(
  parameter int DATA_BITS = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       regs,
  pwlt_req_if.sink   req,
  pwlt_rsp_if.source rsp
);

  localparam int BIDX_W = $clog2(DATA_BITS + 1);

  logic [2:0]         phase, phase_next;
  logic [BIDX_W-1:0]  bit_index, bit_index_next;
  logic [TICK_W-1:0]  tick_count, tick_count_next;
  logic [DATA_BITS:0] frame_bits, frame_bits_next;
  logic               rsp_valid;
  result_t            result, result_next;

  logic [DATA_BITS-1:0] word;
  logic [TICK_W-1:0]    high_len, phase_len;
  logic [TICK_W:0]      tick_inc;
  logic                 req_take;

  // Take a new word whenever the result register is empty or being drained.
  assign req.ready = !rsp_valid || rsp.ready;
  assign req_take  = req.valid && req.ready;

  generate
    if (DATA_BITS <= 8) begin : g_narrow
      assign word = req.data_byte[DATA_BITS-1:0];
    end else begin : g_wide
      assign word = {{(DATA_BITS-8){1'b0}}, req.data_byte};
    end
  endgenerate

  // Current bit sits at the top of the shift register.
  assign high_len = frame_bits[DATA_BITS] ? at_least_one(regs.long_high_ticks)
                                          : at_least_one(regs.short_high_ticks);
  assign tick_inc = {1'b0, tick_count} + (TICK_W+1)'(1);

  always_comb begin
    case (phase)
      PH_START_LOW:   phase_len = at_least_one(regs.start_low_ticks);
      PH_START_PULSE: phase_len = at_least_one(regs.start_pulse_ticks);
      PH_START_GAP:   phase_len = at_least_one(regs.start_gap_ticks);
      PH_BIT_HIGH:    phase_len = high_len;
      PH_BIT_LOW:     phase_len = (high_len < regs.bit_period_ticks)
                                  ? (regs.bit_period_ticks - high_len) : TICK_W'(1);
      PH_STOP:        phase_len = at_least_one(regs.stop_high_ticks);
      default:        phase_len = TICK_W'(1);
    endcase
  end

  always_comb begin
    phase_next      = phase;
    bit_index_next  = bit_index;
    tick_count_next = tick_count;
    frame_bits_next = frame_bits;
    result_next     = '0;
    if (req.action) begin
      if (phase == PH_IDLE && !req.line_busy) begin
        frame_bits_next      = {word, ^word};
        phase_next           = PH_START_LOW;
        bit_index_next       = '0;
        tick_count_next      = '0;
        result_next.accepted = 1'b1;
      end
      result_next.in_progress  = (phase_next != PH_IDLE);
      result_next.drive_enable = (phase_next != PH_IDLE);
      result_next.line_level   = (phase_next != PH_IDLE) ? phase_level(phase_next) : 1'b1;
    end else if (phase == PH_IDLE) begin
      result_next.line_level = 1'b1;
    end else begin
      result_next.line_level   = phase_level(phase);
      result_next.drive_enable = 1'b1;
      result_next.in_progress  = 1'b1;
      if (tick_inc >= {1'b0, phase_len}) begin
        tick_count_next = '0;
        case (phase)
          PH_START_LOW:   phase_next = PH_START_PULSE;
          PH_START_PULSE: phase_next = PH_START_GAP;
          PH_START_GAP: begin
            phase_next     = PH_BIT_HIGH;
            bit_index_next = '0;
          end
          PH_BIT_HIGH:    phase_next = PH_BIT_LOW;
          PH_BIT_LOW: begin
            if (bit_index == BIDX_W'(DATA_BITS)) begin
              phase_next = PH_STOP;
            end else begin
              bit_index_next  = bit_index + BIDX_W'(1);
              frame_bits_next = {frame_bits[DATA_BITS-1:0], 1'b0};
              phase_next      = PH_BIT_HIGH;
            end
          end
          default: begin
            phase_next             = PH_IDLE;
            bit_index_next         = '0;
            result_next.frame_done = 1'b1;
          end
        endcase
      end else begin
        tick_count_next = tick_inc[TICK_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      bit_index  <= '0;
      tick_count <= '0;
      frame_bits <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (req_take) begin
        phase      <= phase_next;
        bit_index  <= bit_index_next;
        tick_count <= tick_count_next;
        frame_bits <= frame_bits_next;
        rsp_valid  <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      result <= result_next;
    end
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.line_level   = result.line_level;
  assign rsp.drive_enable = result.drive_enable;
  assign rsp.in_progress  = result.in_progress;
  assign rsp.accepted     = result.accepted;
  assign rsp.frame_done   = result.frame_done;

endmodule

// ===== hdl/pulse_width_line_transmitter_top.sv =====
// Top level of the pulse-width line transmitter.
// Latency: a result word is registered and appears in the cycle after its request word is taken.
// Throughput: one request word per cycle while rsp.ready is high; the result register drains while the next is taken.
// The rate is set by the combinational next-state update of the phase, bit and tick counters.
// Reset (rst, synchronous, active high) idles the frame sequencer, empties the result
// register and loads the timing registers with their default durations.
module pulse_width_line_transmitter_top
  import pwlt_pkg::*;
#(
  parameter int DATA_BITS = 8
) (
  input  logic       clk,
  input  logic       rst,
  pwlt_req_if.sink   req,
  pwlt_rsp_if.source rsp,
  pwlt_cfg_if.sink   cfg
);

  // Timing registers; writes are expected only while no frame is running.
  cfg_t regs;

  pwlt_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // Sequencer: a send word starts a frame, when idle and the line is not busy, without
  // using time; a tick word reports the current level and advances the counters by one tick.
  pwlt_frame_ctrl #(
    .DATA_BITS (DATA_BITS)
  ) u_frame_ctrl (
    .clk  (clk),
    .rst  (rst),
    .regs (regs),
    .req  (req),
    .rsp  (rsp)
  );

endmodule
